/* hw/rtl/ucodec_pkg.sv */
`timescale 1ns / 1ps

package ucodec_pkg;

	typedef enum logic [1:0] {
		FUNC_U8_DEC  = 2'd0,
		FUNC_U8_ENC  = 2'd1,
		FUNC_U16_DEC = 2'd2,
		FUNC_U16_ENC = 2'd3
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [15:0] unit0;
		logic [15:0] unit1;
		logic [7:0]  unit2;
		logic [7:0]  unit3;
		logic [20:0] code_point;
	} req_t;

	typedef struct packed {
		logic [20:0] decoded_point;
		logic [15:0] out_unit0;
		logic [15:0] out_unit1;
		logic [7:0]  out_unit2;
		logic [7:0]  out_unit3;
		logic [2:0]  unit_count;
		logic        bad_input;
	} rsp_t;

	localparam logic [2:0]  COUNT_ONE   = 3'd1;
	localparam logic [2:0]  COUNT_TWO   = 3'd2;
	localparam logic [2:0]  COUNT_THREE = 3'd3;
	localparam logic [2:0]  COUNT_FOUR  = 3'd4;

	localparam logic [7:0]  U8_LEAD2    = 8'hC0;
	localparam logic [7:0]  U8_LEAD3    = 8'hE0;
	localparam logic [7:0]  U8_LEAD4    = 8'hF0;
	localparam logic [1:0]  U8_CONT_TAG = 2'b10;

	localparam logic [20:0] CP_U8_ONE   = 21'h00_0080;
	localparam logic [20:0] CP_U8_TWO   = 21'h00_0800;
	localparam logic [20:0] CP_BMP_END  = 21'h00_FFFF;
	localparam logic [20:0] CP_SUPP_BASE = 21'h01_0000;
	localparam logic [20:0] CP_MAX      = 21'h10_FFFF;

	localparam logic [15:0] SUR_HI_FIRST = 16'hD800;
	localparam logic [15:0] SUR_HI_LAST  = 16'hDBFF;
	localparam logic [15:0] SUR_LO_FIRST = 16'hDC00;
	localparam logic [15:0] SUR_LO_LAST  = 16'hDFFF;

endpackage

/* hw/rtl/ucodec_req_if.sv */
`timescale 1ns / 1ps

interface ucodec_req_if import ucodec_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/ucodec_rsp_if.sv */
`timescale 1ns / 1ps

interface ucodec_rsp_if import ucodec_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/ucodec_utf8.sv */
`timescale 1ns / 1ps

module ucodec_utf8 import ucodec_pkg::*; (
	input  req_t req,
	input  logic encode,
	output rsp_t rsp
);

	logic [7:0]  b0;
	logic [7:0]  b1;
	logic [20:0] cp;

	assign b0 = req.unit0[7:0];
	assign b1 = req.unit1[7:0];
	assign cp = req.code_point;

	always_comb begin
		rsp = '0;
		if (encode) begin
			if (cp < CP_U8_ONE) begin
				rsp.out_unit0  = {9'd0, cp[6:0]};
				rsp.unit_count = COUNT_ONE;
			end else if (cp < CP_U8_TWO) begin
				rsp.out_unit0  = {8'd0, U8_LEAD2 | {3'd0, cp[10:6]}};
				rsp.out_unit1  = {8'd0, U8_CONT_TAG, cp[5:0]};
				rsp.unit_count = COUNT_TWO;
			end else if (cp <= CP_BMP_END) begin
				rsp.out_unit0  = {8'd0, U8_LEAD3 | {4'd0, cp[15:12]}};
				rsp.out_unit1  = {8'd0, U8_CONT_TAG, cp[11:6]};
				rsp.out_unit2  = {U8_CONT_TAG, cp[5:0]};
				rsp.unit_count = COUNT_THREE;
			end else begin
				rsp.out_unit0  = {8'd0, U8_LEAD4 | {5'd0, cp[20:18]}};
				rsp.out_unit1  = {8'd0, U8_CONT_TAG, cp[17:12]};
				rsp.out_unit2  = {U8_CONT_TAG, cp[11:6]};
				rsp.out_unit3  = {U8_CONT_TAG, cp[5:0]};
				rsp.unit_count = COUNT_FOUR;
			end
		end else begin
			if (!b0[7]) begin
				rsp.decoded_point = {14'd0, b0[6:0]};
				rsp.unit_count    = COUNT_ONE;
			end else if (!b0[6]) begin
				rsp.bad_input = 1'b1;
			end else if (!b0[5]) begin
				rsp.decoded_point = {10'd0, b0[4:0], b1[5:0]};
				rsp.unit_count    = COUNT_TWO;
			end else if (!b0[4]) begin
				rsp.decoded_point = {5'd0, b0[3:0], b1[5:0], req.unit2[5:0]};
				rsp.unit_count    = COUNT_THREE;
			end else if (!b0[3]) begin
				rsp.decoded_point = {b0[2:0], b1[5:0], req.unit2[5:0], req.unit3[5:0]};
				rsp.unit_count    = COUNT_FOUR;
			end else begin
				rsp.bad_input = 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/ucodec_utf16.sv */
`timescale 1ns / 1ps

module ucodec_utf16 import ucodec_pkg::*; (
	input  req_t req,
	input  logic encode,
	output rsp_t rsp
);

	logic        u0_hi;
	logic        u0_lo;
	logic        u1_lo;
	logic [20:0] cp;
	logic [19:0] offset;

	assign u0_hi  = (req.unit0 >= SUR_HI_FIRST) && (req.unit0 <= SUR_HI_LAST);
	assign u0_lo  = (req.unit0 >= SUR_LO_FIRST) && (req.unit0 <= SUR_LO_LAST);
	assign u1_lo  = (req.unit1 >= SUR_LO_FIRST) && (req.unit1 <= SUR_LO_LAST);
	assign cp     = req.code_point;
	assign offset = cp[19:0] - CP_SUPP_BASE[19:0];

	always_comb begin
		rsp = '0;
		if (encode) begin
			if (cp <= CP_BMP_END) begin
				if ((cp[15:0] >= SUR_HI_FIRST) && (cp[15:0] <= SUR_LO_LAST)) begin
					rsp.bad_input = 1'b1;
				end else begin
					rsp.out_unit0  = cp[15:0];
					rsp.unit_count = COUNT_ONE;
				end
			end else if (cp <= CP_MAX) begin
				rsp.out_unit0  = SUR_HI_FIRST | {6'd0, offset[19:10]};
				rsp.out_unit1  = SUR_LO_FIRST | {6'd0, offset[9:0]};
				rsp.unit_count = COUNT_TWO;
			end else begin
				rsp.bad_input = 1'b1;
			end
		end else begin
			if (u0_lo || (u0_hi && !u1_lo)) begin
				rsp.bad_input = 1'b1;
			end else if (u0_hi) begin
				rsp.decoded_point = CP_SUPP_BASE + {1'b0, req.unit0[9:0], req.unit1[9:0]};
				rsp.unit_count    = COUNT_TWO;
			end else begin
				rsp.decoded_point = {5'd0, req.unit0};
				rsp.unit_count    = COUNT_ONE;
			end
		end
	end

endmodule

/* hw/rtl/unicode_utf8_utf16_codec.sv */
`timescale 1ns / 1ps

// UTF-8 / UTF-16 codec. Each request on the item channel names one operation
// (UTF-8 decode or encode, UTF-16 decode or encode) and carries the code units
// to decode and the code point to encode. Exactly one result leaves on the
// result channel for every request, in request order.
// The block has two register stages: the request is captured in an input
// register, the conversion is done by combinational logic, and the answer is
// held in a result register. The result is valid once the request has passed
// through the input register into the result register, and one request is
// accepted every cycle when the receiver takes results every cycle.
// When the receiver stalls, the result register holds its value and the input
// register fills; item.ready drops only when both stages are full and the
// receiver is not ready, so no request is lost or repeated.
// Reset clears both stage valid flags; the data registers are not reset, and the
// block is ready for a request as soon as reset is released.
module unicode_utf8_utf16_codec import ucodec_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ucodec_req_if.sink   item,
	ucodec_rsp_if.source result
);

	req_t data_s1;
	logic valid_s1;
	rsp_t data_s2;
	logic valid_s2;
	logic adv_s1;
	logic adv_s2;
	rsp_t u8_rsp;
	rsp_t u16_rsp;
	rsp_t next_rsp;

	assign adv_s2     = !valid_s2 || result.ready;
	assign adv_s1     = !valid_s1 || adv_s2;
	assign item.ready = adv_s1;

	ucodec_utf8 u_utf8 (
		.req    (data_s1),
		.encode (data_s1.func == FUNC_U8_ENC),
		.rsp    (u8_rsp)
	);

	ucodec_utf16 u_utf16 (
		.req    (data_s1),
		.encode (data_s1.func == FUNC_U16_ENC),
		.rsp    (u16_rsp)
	);

	always_comb begin
		unique case (data_s1.func)
			FUNC_U8_DEC, FUNC_U8_ENC: next_rsp = u8_rsp;
			FUNC_U16_DEC, FUNC_U16_ENC: next_rsp = u16_rsp;
			default: next_rsp = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= item.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item.valid) begin
			data_s1 <= item.data;
		end
		if (adv_s2 && valid_s1) begin
			data_s2 <= next_rsp;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = data_s2;

	a_bad_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && data_s2.bad_input) |-> (data_s2.unit_count == 3'd0) &&
		(data_s2.decoded_point == '0) && (data_s2.out_unit0 == '0))
		else $error("error result carries nonzero fields");

	a_good_count: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !data_s2.bad_input) |->
		(data_s2.unit_count != 3'd0) && (data_s2.unit_count <= COUNT_FOUR))
		else $error("good result has count out of range");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("first stage did not move into empty result stage");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (valid_s1 && valid_s2 && !result.ready))
		else $error("request refused while pipeline has room");

endmodule

/* bench/tb_unicode_utf8_utf16_codec.sv */
`timescale 1ns / 1ps

module tb_unicode_utf8_utf16_codec;
	import ucodec_pkg::*;

	localparam time         CLK_PERIOD   = 12ns;
	localparam int unsigned RESET_CYCLES = 9;
	localparam int unsigned RANDOM_ITEMS = 900;
	localparam int unsigned IDLE_PCT     = 36;
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned DRAIN_CYCLES = 8;

	class codec_scoreboard;
		rsp_t        expected_q[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		function bit is_hi_sur(logic [15:0] u);
			return u >= SUR_HI_FIRST && u <= SUR_HI_LAST;
		endfunction

		function bit is_lo_sur(logic [15:0] u);
			return u >= SUR_LO_FIRST && u <= SUR_LO_LAST;
		endfunction

		function rsp_t convert(req_t r);
			rsp_t        o;
			logic [7:0]  b0;
			logic [7:0]  b1;
			logic [7:0]  b2;
			logic [7:0]  b3;
			logic [20:0] cp;
			logic [20:0] v;
			logic [2:0]  n;
			o = '0;
			b0 = r.unit0[7:0];
			b1 = r.unit1[7:0];
			b2 = r.unit2;
			b3 = r.unit3;
			cp = r.code_point;
			case (r.func)
				FUNC_U8_DEC: begin
					casez (b0[7:3])
						5'b0????: n = COUNT_ONE;
						5'b110??: n = COUNT_TWO;
						5'b1110?: n = COUNT_THREE;
						5'b11110: n = COUNT_FOUR;
						default:  n = '0;
					endcase
					case (n)
						COUNT_ONE:   o.decoded_point = {14'd0, b0[6:0]};
						COUNT_TWO:   o.decoded_point = {10'd0, b0[4:0], b1[5:0]};
						COUNT_THREE: o.decoded_point = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
						COUNT_FOUR:  o.decoded_point = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
						default:     o.bad_input = 1'b1;
					endcase
					o.unit_count = n;
				end
				FUNC_U8_ENC: begin
					if (cp < CP_U8_ONE) begin
						o.out_unit0 = {9'd0, cp[6:0]};
						o.unit_count = COUNT_ONE;
					end else if (cp < CP_U8_TWO) begin
						o.out_unit0 = {8'd0, U8_LEAD2 | {3'd0, cp[10:6]}};
						o.out_unit1 = {8'd0, U8_CONT_TAG, cp[5:0]};
						o.unit_count = COUNT_TWO;
					end else if (cp < CP_SUPP_BASE) begin
						o.out_unit0 = {8'd0, U8_LEAD3 | {4'd0, cp[15:12]}};
						o.out_unit1 = {8'd0, U8_CONT_TAG, cp[11:6]};
						o.out_unit2 = {U8_CONT_TAG, cp[5:0]};
						o.unit_count = COUNT_THREE;
					end else begin
						o.out_unit0 = {8'd0, U8_LEAD4 | {5'd0, cp[20:18]}};
						o.out_unit1 = {8'd0, U8_CONT_TAG, cp[17:12]};
						o.out_unit2 = {U8_CONT_TAG, cp[11:6]};
						o.out_unit3 = {U8_CONT_TAG, cp[5:0]};
						o.unit_count = COUNT_FOUR;
					end
				end
				FUNC_U16_DEC: begin
					if (is_lo_sur(r.unit0)) begin
						o.bad_input = 1'b1;
					end else if (is_hi_sur(r.unit0)) begin
						if (is_lo_sur(r.unit1)) begin
							o.decoded_point = CP_SUPP_BASE + {1'b0, r.unit0[9:0], r.unit1[9:0]};
							o.unit_count = COUNT_TWO;
						end else begin
							o.bad_input = 1'b1;
						end
					end else begin
						o.decoded_point = {5'd0, r.unit0};
						o.unit_count = COUNT_ONE;
					end
				end
				default: begin
					if (cp <= CP_BMP_END) begin
						if (is_hi_sur(cp[15:0]) || is_lo_sur(cp[15:0])) begin
							o.bad_input = 1'b1;
						end else begin
							o.out_unit0 = cp[15:0];
							o.unit_count = COUNT_ONE;
						end
					end else if (cp <= CP_MAX) begin
						v = cp - CP_SUPP_BASE;
						o.out_unit0 = SUR_HI_FIRST + {6'd0, v[19:10]};
						o.out_unit1 = SUR_LO_FIRST + {6'd0, v[9:0]};
						o.unit_count = COUNT_TWO;
					end else begin
						o.bad_input = 1'b1;
					end
				end
			endcase
			return o;
		endfunction

		function void note_request(req_t r);
			expected_q.push_back(convert(r));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task compare_field(string name, logic [20:0] got, logic [20:0] want);
			if (got !== want)
				report($sformatf("%s is %h, expected %h", name, got, want));
		endtask

		task check_result(rsp_t got);
			rsp_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result %h arrived with no request outstanding", got));
				return;
			end
			want = expected_q.pop_front();
			compare_field("decoded_point", got.decoded_point, want.decoded_point);
			compare_field("out_unit0", got.out_unit0, want.out_unit0);
			compare_field("out_unit1", got.out_unit1, want.out_unit1);
			compare_field("out_unit2", got.out_unit2, want.out_unit2);
			compare_field("out_unit3", got.out_unit3, want.out_unit3);
			compare_field("unit_count", got.unit_count, want.unit_count);
			compare_field("bad_input", got.bad_input, want.bad_input);
		endtask
	endclass

	logic            clk = 1'b0;
	logic            arst_n;
	bit              calm = 1'b0;
	int unsigned     quiet_cycles = 0;
	codec_scoreboard sb;

	ucodec_req_if req_ch ();
	ucodec_rsp_if rsp_ch ();

	unicode_utf8_utf16_codec i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (req_ch.sink),
		.result (rsp_ch.source)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic req_t mk(func_t f, logic [15:0] u0, logic [15:0] u1,
			logic [7:0] u2, logic [7:0] u3, logic [20:0] cp);
		req_t r;
		r.func = f;
		r.unit0 = u0;
		r.unit1 = u1;
		r.unit2 = u2;
		r.unit3 = u3;
		r.code_point = cp;
		return r;
	endfunction

	function automatic logic [7:0] cont_byte();
		if ($urandom_range(9) == 0)
			return 8'($urandom);
		return {U8_CONT_TAG, 6'($urandom)};
	endfunction

	function automatic req_t random_request();
		req_t       r;
		logic [7:0] lead;
		r.func = func_t'($urandom_range(3));
		r.unit0 = 16'($urandom);
		r.unit1 = 16'($urandom);
		r.unit2 = 8'($urandom);
		r.unit3 = 8'($urandom);
		r.code_point = 21'($urandom);
		case (r.func)
			FUNC_U8_DEC: begin
				case ($urandom_range(5))
					0: lead = {1'b0, 7'($urandom)};
					1: lead = U8_LEAD2 | {3'd0, 5'($urandom)};
					2: lead = U8_LEAD3 | {4'd0, 4'($urandom)};
					3: lead = U8_LEAD4 | {5'd0, 3'($urandom)};
					default: lead = 8'($urandom);
				endcase
				r.unit0[7:0] = lead;
				r.unit1[7:0] = cont_byte();
				r.unit2 = cont_byte();
				r.unit3 = cont_byte();
			end
			FUNC_U8_ENC: begin
				case ($urandom_range(4))
					0: r.code_point = 21'($urandom_range(CP_U8_ONE - 1));
					1: r.code_point = 21'($urandom_range(CP_U8_ONE, CP_U8_TWO - 1));
					2: r.code_point = 21'($urandom_range(CP_U8_TWO, CP_BMP_END));
					3: r.code_point = 21'($urandom_range(CP_SUPP_BASE, CP_MAX));
					default: ;
				endcase
			end
			FUNC_U16_DEC: begin
				case ($urandom_range(5))
					0, 1: begin
						r.unit0 = 16'($urandom_range(SUR_HI_FIRST, SUR_HI_LAST));
						r.unit1 = 16'($urandom_range(SUR_LO_FIRST, SUR_LO_LAST));
					end
					2: r.unit0 = 16'($urandom_range(SUR_HI_FIRST, SUR_HI_LAST));
					3: r.unit0 = 16'($urandom_range(SUR_LO_FIRST, SUR_LO_LAST));
					default: ;
				endcase
			end
			default: begin
				case ($urandom_range(4))
					0: r.code_point = 21'($urandom_range(CP_BMP_END));
					1: r.code_point = 21'($urandom_range(SUR_HI_FIRST, SUR_LO_LAST));
					2: r.code_point = 21'($urandom_range(CP_SUPP_BASE, CP_MAX));
					3: r.code_point = 21'($urandom_range(CP_MAX + 1, 21'h1F_FFFF));
					default: ;
				endcase
			end
		endcase
		return r;
	endfunction

	task automatic send_request(req_t r);
		bit fire;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do begin
			@(negedge clk);
			fire = req_ch.ready;
			if (fire)
				sb.note_request(r);
			@(posedge clk);
		end while (!fire);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		rsp_ch.ready <= arst_n && (calm || ($urandom_range(99) >= IDLE_PCT));
	end

	always @(negedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready)
			sb.check_result(rsp_ch.data);
	end

	always @(negedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready === 1'b1)
				|| (rsp_ch.valid === 1'b1 && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(mk(FUNC_U8_DEC, 16'hFF7F, 16'hFFFF, 8'hFF, 8'hFF, 21'h1F_FFFF));
		send_request(mk(FUNC_U8_DEC, 16'h0080, 16'h0080, 8'h80, 8'h80, 21'h0));
		send_request(mk(FUNC_U8_DEC, 16'h00F8, 16'h0080, 8'h80, 8'h80, 21'h0));
		send_request(mk(FUNC_U8_DEC, 16'hABC2, 16'h12A9, 8'h00, 8'h00, 21'h0));
		send_request(mk(FUNC_U8_DEC, 16'h00E2, 16'h0082, 8'hAC, 8'h55, 21'h0));
		send_request(mk(FUNC_U8_DEC, 16'h00F4, 16'h008F, 8'hBF, 8'hBF, 21'h0));
		send_request(mk(FUNC_U8_DEC, 16'h00F7, 16'h00FF, 8'h3F, 8'hFF, 21'h0));
		send_request(mk(FUNC_U8_DEC, 16'h00ED, 16'h00A0, 8'h80, 8'h00, 21'h0));
		send_request(mk(FUNC_U8_DEC, 16'h00C0, 16'h0080, 8'h00, 8'h00, 21'h0));
		send_request(mk(FUNC_U8_ENC, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 21'h00_007F));
		send_request(mk(FUNC_U8_ENC, 16'h0000, 16'h0000, 8'h00, 8'h00, 21'h00_0080));
		send_request(mk(FUNC_U8_ENC, 16'h0000, 16'h0000, 8'h00, 8'h00, 21'h00_07FF));
		send_request(mk(FUNC_U8_ENC, 16'h0000, 16'h0000, 8'h00, 8'h00, 21'h00_0800));
		send_request(mk(FUNC_U8_ENC, 16'h0000, 16'h0000, 8'h00, 8'h00, 21'h00_FFFF));
		send_request(mk(FUNC_U8_ENC, 16'h0000, 16'h0000, 8'h00, 8'h00, 21'h01_0000));
		send_request(mk(FUNC_U8_ENC, 16'h0000, 16'h0000, 8'h00, 8'h00, 21'h1F_FFFF));
		send_request(mk(FUNC_U16_DEC, 16'hDC00, 16'hDC00, 8'h00, 8'h00, 21'h0));
		send_request(mk(FUNC_U16_DEC, 16'hD800, 16'h0041, 8'h00, 8'h00, 21'h0));
		send_request(mk(FUNC_U16_DEC, 16'hDBFF, 16'hDFFF, 8'h00, 8'h00, 21'h0));
		send_request(mk(FUNC_U16_DEC, 16'hD800, 16'hDC00, 8'h00, 8'h00, 21'h0));
		send_request(mk(FUNC_U16_DEC, 16'hFFFF, 16'hDBFF, 8'h00, 8'h00, 21'h0));
		send_request(mk(FUNC_U16_ENC, 16'h0000, 16'h0000, 8'h00, 8'h00, 21'h00_D800));
		send_request(mk(FUNC_U16_ENC, 16'h0000, 16'h0000, 8'h00, 8'h00, 21'h00_DFFF));
		send_request(mk(FUNC_U16_ENC, 16'h0000, 16'h0000, 8'h00, 8'h00, 21'h00_FFFF));
		send_request(mk(FUNC_U16_ENC, 16'h0000, 16'h0000, 8'h00, 8'h00, 21'h01_0000));
		send_request(mk(FUNC_U16_ENC, 16'h0000, 16'h0000, 8'h00, 8'h00, 21'h10_FFFF));
		send_request(mk(FUNC_U16_ENC, 16'h0000, 16'h0000, 8'h00, 8'h00, 21'h11_0000));

		// The sender holds off here until the result channel has fully caught up.
		drain_results();

		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			calm <= (n >= 400 && n < 550);
			if (n == 700)
				drain_results();
			send_request(random_request());
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
